// ===== rtl/ffd_pkg.sv =====
`default_nettype none
package ffd_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SAMPLE_W    = 16;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_DELAY  = 3'd1;
  localparam logic [2:0] REG_RATE   = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_WET    = 3'd4;
  localparam logic [2:0] REG_COEFF  = 3'd5;

  localparam logic [6:0]  RATE_DIV     = 7'd125;
  localparam logic [23:0] RATE_RECIP   = 24'd8589935;
  localparam logic [4:0]  CLIP_STEPS   = 5'd18;
  localparam logic [36:0] CLIP_K       = 37'd28991029248;
  localparam logic [17:0] CLIP_MAG_MAX = 18'd200000;

  typedef struct packed {
    logic        mode;
    logic [23:0] delay;
    logic [17:0] rate;
    logic [14:0] gain;
    logic [15:0] wet;
    logic [15:0] coeff;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/feedback_fractional_delay_top.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] audio_in, tdata[31:16] modulation
// m_axis    out        tdata[15:0] audio_out
// cfg       in         cfg_idx_i register index, cfg_wdata_i value
//
// A sample is taken only while the core is idle, after the last one is done.
// The bit-serial soft-clip divider (18 steps) and the single store port bound
// the sample rate. The rate scaling in mode 1 adds the states T1, T2 and T3.
// After reset all 65536 store entries are zeroed one entry per cycle, with
// s_axis_tready low. One output register holds a finished sample, so the
// next sample is taken while m_axis waits.
`default_nettype none
module feedback_fractional_delay_top
  import ffd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] audio_in, [31:16] modulation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] audio_out
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i
);

  cfg_t        cfg_q;
  logic        res_valid, res_ready;
  logic [15:0] res_data;
  logic        out_valid_q;
  logic [15:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= 1'b0;
      cfg_q.delay <= '0;
      cfg_q.rate  <= 18'd48000;
      cfg_q.gain  <= '0;
      cfg_q.wet   <= '0;
      cfg_q.coeff <= 16'd131;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  cfg_q.mode  <= cfg_wdata_i[0];
        REG_DELAY: cfg_q.delay <= cfg_wdata_i;
        REG_RATE:  cfg_q.rate  <= cfg_wdata_i[17:0];
        REG_GAIN:  cfg_q.gain  <= cfg_wdata_i[14:0];
        REG_WET:   cfg_q.wet   <= cfg_wdata_i[15:0];
        REG_COEFF: cfg_q.coeff <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  ffd_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .audio_i     (s_axis_tdata[15:0]),
    .mod_i       (s_axis_tdata[31:16]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("finished sample not presented");
`endif

endmodule
`default_nettype wire

// ===== rtl/ffd_div.sv =====
`default_nettype none
module ffd_div
  import ffd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [53:0] dividend_i,
  input  wire logic [55:0] divisor_sh_i,
  input  wire logic [4:0]  steps_i,
  output logic             busy_o,
  output logic [26:0]      quo_o
);

  logic [53:0] rem_q, rem_d;
  logic [55:0] dsh_q, dsh_d;
  logic [26:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        ge;

  assign ge = {2'b00, rem_q} >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i && !busy_q) begin
      rem_d  = dividend_i;
      dsh_d  = divisor_sh_i;
      quo_d  = '0;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q[53:0];
      end
      quo_d = {quo_q[25:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/ffd_core.sv =====
`default_nettype none
module ffd_core
  import ffd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] audio_i,
  input  wire logic [15:0] mod_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [15:0]      res_data_o
);

  typedef enum logic [19:0] {
    ST_CLEAR = 20'd1 << 0,
    ST_IDLE  = 20'd1 << 1,
    ST_T0    = 20'd1 << 2,
    ST_T1    = 20'd1 << 3,
    ST_T2    = 20'd1 << 4,
    ST_T3    = 20'd1 << 5,
    ST_S1    = 20'd1 << 6,
    ST_S2    = 20'd1 << 7,
    ST_S3    = 20'd1 << 8,
    ST_R0    = 20'd1 << 9,
    ST_R1    = 20'd1 << 10,
    ST_I0    = 20'd1 << 11,
    ST_C0    = 20'd1 << 12,
    ST_C1    = 20'd1 << 13,
    ST_C2    = 20'd1 << 14,
    ST_C3    = 20'd1 << 15,
    ST_C4    = 20'd1 << 16,
    ST_M0    = 20'd1 << 17,
    ST_M1    = 20'd1 << 18,
    ST_M2    = 20'd1 << 19
  } state_e;

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0] store_q [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [ADDR_W-1:0]   addr;
  logic                we;
  logic [SAMPLE_W-1:0] wdata;

  logic [ADDR_W-1:0] clr_q, wp_q;
  logic [31:0]       s_q;
  logic [15:0]       fb_q;

  logic [15:0] x_q, m_q;
  logic [33:0] tprod_q;
  logic [11:0] qh_q;
  logic [22:0] tlo_q;
  logic [31:0] target_q;
  logic [48:0] p1_q;
  logic [47:0] p2_q;
  logic signed [34:0] acc_q;
  logic [15:0] sample_q;
  logic        neg_q;
  logic [17:0] mag_q;
  logic [35:0] a2_q;
  logic [53:0] num_q;
  logic [38:0] den_q;
  logic signed [33:0] mix_q;

  logic        div_start, div_busy;
  logic [53:0] div_dvd;
  logic [55:0] div_dsh;
  logic [4:0]  div_steps;
  logic [26:0] div_quo;

  logic [18:0] kk;
  logic [35:0] rk;
  logic [41:0] qh_prod;
  logic [6:0]  hrem;
  logic [46:0] lo_prod;
  logic [49:0] ssum;
  logic [31:0] pnt;
  logic [15:0] ip, fr, i0;
  logic [16:0] w0;
  logic signed [31:0] fbg;
  logic [33:0] sumv;
  logic [18:0] av, magf;
  logic [36:0] tk;
  logic [54:0] nump;
  logic [17:0] qv;
  logic [15:0] clipv;
  logic [15:0] wet, dry;
  logic [18:0] ov;
  logic [15:0] osat;

  ffd_div u_div (
    .clk_i,
    .rst_ni,
    .start_i      (div_start),
    .dividend_i   (div_dvd),
    .divisor_sh_i (div_dsh),
    .steps_i      (div_steps),
    .busy_o       (div_busy),
    .quo_o        (div_quo)
  );

  assign kk      = 19'd98304 + {{2{m_q[15]}}, m_q, 1'b0};
  assign rk      = cfg_i.rate * kk[17:0];
  assign qh_prod = tprod_q[33:16] * RATE_RECIP;
  assign hrem    = 7'(tprod_q[33:16] - 18'(qh_q * RATE_DIV));
  assign lo_prod = tlo_q * RATE_RECIP;
  assign ssum = {1'b0, p1_q} + {2'b00, p2_q};
  assign pnt  = {wp_q, 16'h0000} - s_q;
  assign ip   = pnt[31:16];
  assign fr   = pnt[15:0];
  assign i0   = ip - 16'd1;
  assign w0   = 17'h10000 - {1'b0, fr};
  assign fbg  = $signed(fb_q) * $signed({1'b0, cfg_i.gain});
  assign sumv = {{3{x_q[15]}}, x_q, 15'h0000} + {fbg[31], fbg, 1'b0};
  assign av   = sumv[33:15];
  assign magf = av[18] ? (19'd0 - av) : av;
  assign tk   = CLIP_K + {1'b0, a2_q};
  assign nump = mag_q * tk;
  assign qv   = div_quo[17:0];
  assign wet  = (cfg_i.wet > 16'd32768) ? 16'd32768 : cfg_i.wet;
  assign dry  = 16'd32768 - wet;
  assign ov   = mix_q[33:15];

  always_comb begin
    if (neg_q) begin
      clipv = (qv > 18'd32768) ? 16'h8000 : 16'(18'd0 - qv);
    end else begin
      clipv = (qv > 18'd32767) ? 16'h7FFF : qv[15:0];
    end
  end

  always_comb begin
    if (!ov[18] && (ov[17:15] != 3'b000)) begin
      osat = 16'h7FFF;
    end else if (ov[18] && (ov[17:15] != 3'b111)) begin
      osat = 16'h8000;
    end else begin
      osat = ov[15:0];
    end
  end

  assign div_start = state_q == ST_C3;
  assign div_dvd   = num_q;
  assign div_dsh   = {den_q, 17'd0};
  assign div_steps = CLIP_STEPS;

  always_comb begin
    addr  = wp_q;
    we    = 1'b0;
    wdata = clipv;
    case (state_q)
      ST_CLEAR: begin
        addr  = clr_q;
        we    = 1'b1;
        wdata = '0;
      end
      ST_R0: addr = i0;
      ST_R1: addr = ip;
      ST_C4: we = !div_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[addr] <= wdata;
    end
    rdata_q <= store_q[addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(STORE_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_T0;
      ST_T0:    state_d = cfg_i.mode ? ST_T1 : ST_S1;
      ST_T1:    state_d = ST_T2;
      ST_T2:    state_d = ST_T3;
      ST_T3:    state_d = ST_S1;
      ST_S1:    state_d = ST_S2;
      ST_S2:    state_d = ST_S3;
      ST_S3:    state_d = ST_R0;
      ST_R0:    state_d = ST_R1;
      ST_R1:    state_d = ST_I0;
      ST_I0:    state_d = ST_C0;
      ST_C0:    state_d = ST_C1;
      ST_C1:    state_d = ST_C2;
      ST_C2:    state_d = ST_C3;
      ST_C3:    state_d = ST_C4;
      ST_C4:    if (!div_busy) state_d = ST_M0;
      ST_M0:    state_d = ST_M1;
      ST_M1:    state_d = ST_M2;
      ST_M2:    if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      s_q     <= '0;
      fb_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (state_q == ST_S3) s_q <= ssum[47:16];
      if ((state_q == ST_C4) && !div_busy) fb_q <= sample_q;
      if ((state_q == ST_M2) && res_ready_i) wp_q <= wp_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q <= audio_i;
        m_q <= mod_i;
      end
      ST_T0: begin
        tprod_q  <= rk[35:2];
        target_q <= {cfg_i.delay, 8'h00};
      end
      ST_T1: qh_q <= qh_prod[41:30];
      ST_T2: tlo_q <= {hrem, tprod_q[15:0]};
      ST_T3: target_q <= {4'd0, qh_q, lo_prod[45:30]};
      ST_S1: p1_q <= s_q * (17'h10000 - {1'b0, cfg_i.coeff});
      ST_S2: p2_q <= target_q * cfg_i.coeff;
      ST_R1: acc_q <= 35'($signed(rdata_q) * $signed({1'b0, w0}));
      ST_I0: acc_q <= acc_q + 35'($signed(rdata_q) * $signed({2'b00, fr}));
      ST_C0: begin
        sample_q <= acc_q[31:16];
        neg_q    <= av[18];
        mag_q    <= (magf > {1'b0, CLIP_MAG_MAX}) ? CLIP_MAG_MAX : magf[17:0];
      end
      ST_C1: a2_q <= mag_q * mag_q;
      ST_C2: begin
        num_q <= nump[53:0];
        den_q <= {2'b00, CLIP_K} + {a2_q, 3'b000} + {3'b000, a2_q};
      end
      ST_M0: mix_q <= 34'($signed(x_q) * $signed({1'b0, dry}));
      ST_M1: mix_q <= mix_q + 34'($signed(sample_q) * $signed({1'b0, wet}));
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_M2;
  assign res_data_o  = osat;

endmodule
`default_nettype wire

// ===== tb/sv/feedback_fractional_delay_top_tb.sv =====
`default_nettype none
module feedback_fractional_delay_top_tb
  import ffd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  class delay_scoreboard;
    logic [15:0] store_mem [STORE_DEPTH];
    logic [15:0] wr_pos;
    logic [31:0] smooth_dly;
    logic signed [15:0] fb_smp;
    logic        cfg_mode;
    logic [23:0] cfg_delay;
    logic [17:0] cfg_rate;
    logic [14:0] cfg_gain;
    logic [15:0] cfg_wet;
    logic [15:0] cfg_coeff;
    logic [15:0] pending_out[$];
    int errors;

    function new();
      foreach (store_mem[k]) store_mem[k] = '0;
      wr_pos = 0; smooth_dly = 0; fb_smp = 0;
      cfg_mode = 0; cfg_delay = 0; cfg_rate = 48000; cfg_gain = 0;
      cfg_wet = 0; cfg_coeff = 131; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_MODE:  cfg_mode = val[0];
        REG_DELAY: cfg_delay = val;
        REG_RATE:  cfg_rate = val[17:0];
        REG_GAIN:  cfg_gain = val[14:0];
        REG_WET:   cfg_wet = val[15:0];
        REG_COEFF: cfg_coeff = val[15:0];
        default: ;
      endcase
    endfunction

    function longint fshr(longint v, int k);
      return v >>> k;
    endfunction

    function logic [15:0] soft_sat(longint v);
      longint a;
      logic neg;
      longint unsigned mag, a2, num, den, q;
      a = fshr(v, 15);
      neg = a < 0;
      mag = neg ? -a : a;
      if (mag > 200000) mag = 200000;
      a2 = mag * mag;
      num = mag * ((64'd27 << 30) + a2);
      den = (64'd27 << 30) + 9 * a2;
      q = ((num << 8) / den) >> 8;
      if (neg) begin
        if (q > 32768) q = 32768;
        return 16'(-longint'(q));
      end
      if (q > 32767) q = 32767;
      return 16'(q);
    endfunction

    function void note_sample(logic [31:0] beat);
      longint x, m, y0, y1, smp, sum, acc, o;
      longint unsigned tgt, c, p, ip, fr, wet;
      x = longint'($signed(beat[15:0]));
      m = longint'($signed(beat[31:16]));
      if (!cfg_mode) tgt = longint'(cfg_delay) << 8;
      else tgt = (longint'(cfg_rate) * longint'(98304 + 2 * m) * 2) / 1000;
      c = cfg_coeff;
      smooth_dly = 32'((longint'(smooth_dly) * (65536 - c) + tgt * c) >> 16);
      p = ((longint'(wr_pos) << 16) - longint'(smooth_dly)) & 64'hFFFF_FFFF;
      ip = p >> 16;
      fr = p & 16'hFFFF;
      y0 = longint'($signed(store_mem[16'(ip - 1)]));
      y1 = longint'($signed(store_mem[16'(ip)]));
      smp = fshr(y0 * longint'(65536 - fr) + y1 * longint'(fr), 16);
      sum = x * 32768 + fshr(longint'(fb_smp) * 32768 * longint'(cfg_gain), 14);
      store_mem[wr_pos] = soft_sat(sum);
      fb_smp = 16'(smp);
      wet = cfg_wet > 32768 ? 32768 : cfg_wet;
      acc = x * longint'(32768 - wet) * 32768 + smp * 32768 * longint'(wet);
      o = fshr(acc, 30);
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      pending_out.push_back(16'(o));
      wr_pos = wr_pos + 1;
    endfunction

    function void check_sample(logic [15:0] got);
      logic [15:0] want;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_out.pop_front();
      if (got !== want) begin
        $display("%0t: audio_out mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [23:0] cfg_wdata_i;

  delay_scoreboard sb;
  bit quiet_stretch;
  bit hold_off;

  feedback_fractional_delay_top dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #500ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [15:0] audio, logic [15:0] modv);
    while (!quiet_stretch && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {modv, audio};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample({modv, audio});
  endtask

  task automatic drain();
    while (sb.pending_out.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_smp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int k = 0; k < n; k++) send_sample(rand_smp(), rand_smp());
    s_axis_tvalid <= 0;
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
    m_axis_tready <= hold_off ? 1'b0 : (quiet_stretch || $urandom_range(99) >= 8);
  end

  initial begin
    sb = new();
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = 0; m_axis_tready = 0;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_wdata_i = 0;
    quiet_stretch = 0; hold_off = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    write_reg(REG_WET, 24'd16384);
    write_reg(REG_DELAY, 24'd768);
    write_reg(REG_COEFF, 24'd65535);
    write_reg(REG_GAIN, 24'd8192);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0001, 16'hFFFF);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    s_axis_tvalid <= 0;
    drain();
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    write_reg(REG_GAIN, 24'd19661);
    write_reg(REG_WET, 24'd65535);
    write_reg(REG_COEFF, 24'd0);
    for (int k = 0; k < 6; k++) send_sample(16'h7FFF, 16'h8000);
    s_axis_tvalid <= 0;
    drain();
    write_reg(REG_GAIN, 24'h7FFF);
    write_reg(REG_DELAY, 24'hFFFFFF);
    write_reg(REG_COEFF, 24'd65535);
    for (int k = 0; k < 6; k++) send_sample(16'h8000, 16'h7FFF);
    s_axis_tvalid <= 0;
    drain();

    write_reg(REG_GAIN, 24'd12000);
    write_reg(REG_WET, 24'd32768);
    write_reg(REG_DELAY, 24'd2000);
    write_reg(REG_COEFF, 24'd131);
    random_burst(330);

    quiet_stretch = 1;
    write_reg(REG_MODE, 24'd1);
    write_reg(REG_RATE, 24'd8000);
    write_reg(REG_COEFF, 24'd40000);
    random_burst(200);
    quiet_stretch = 0;

    write_reg(REG_RATE, 24'h3FFFF);
    write_reg(REG_GAIN, 24'd19661);
    write_reg(REG_WET, 24'd20000);
    random_burst(250);

    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      random_burst(150);
    join

    write_reg(REG_MODE, 24'd0);
    write_reg(REG_DELAY, 24'($urandom_range(24'hFFFFFF)));
    write_reg(REG_COEFF, 24'd1);
    write_reg(REG_GAIN, 24'd0);
    random_burst(200);

    write_reg(REG_MODE, 24'd1);
    write_reg(REG_RATE, 24'd192000);
    write_reg(REG_GAIN, 24'($urandom_range(19661)));
    write_reg(REG_WET, 24'($urandom_range(32768)));
    write_reg(REG_COEFF, 24'($urandom_range(1, 65535)));
    random_burst(250);

    write_reg(REG_MODE, 24'd0);
    write_reg(REG_DELAY, 24'($urandom_range(4096)));
    write_reg(REG_RATE, 24'd0);
    write_reg(REG_WET, 24'd0);
    random_burst(150);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
